>>> hdl/pfde_pkg.sv
package pfde_pkg;

  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam int PAGE_ROWS       = 8;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_START = 1'b1;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic clr_step;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic bad;
    logic empty;
    logic last_byte;
    logic clr_last;
  } dp_sts_t;

endpackage

>>> hdl/pfde_in_if.sv
interface pfde_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic       pixel_on;
  logic [9:0] read_index;

  modport source (
    output valid, command, pos_x, pos_y, rect_width, rect_height, pixel_on, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, rect_width, rect_height, pixel_on, read_index,
    output ready
  );
endinterface

>>> hdl/pfde_out_if.sv
interface pfde_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_byte;

  modport source (
    output valid, status, read_byte,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte,
    output ready
  );
endinterface

>>> hdl/pfde_ctrl.sv
module pfde_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfde_pkg::dp_cmd_t cmd_o,
  input  pfde_pkg::dp_sts_t sts_i
);
  import pfde_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_fin;

  assign can_fin = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.cmd)
          CMD_CLEAR: state_d = S_CLR;
          CMD_READ: begin
            cmd_o.rd = 1'b1;
            state_d  = S_FIN;
          end
          default: begin
            if (sts_i.bad || sts_i.empty) begin
              cmd_o.res_load = can_fin;
              state_d        = can_fin ? S_IDLE : S_FIN;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_WR;
            end
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        if (sts_i.last_byte) begin
          cmd_o.res_load = can_fin;
          state_d        = can_fin ? S_IDLE : S_FIN;
        end else begin
          state_d = S_RD;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (can_fin) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/pfde_dp.sv
module pfde_dp #(
  parameter int DISP_WIDTH  = pfde_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = pfde_pkg::DISP_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfde_pkg::dp_cmd_t cmd_i,
  output pfde_pkg::dp_sts_t sts_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        pos_x_i,
  input  logic [7:0]        pos_y_i,
  input  logic [7:0]        rect_width_i,
  input  logic [7:0]        rect_height_i,
  input  logic              pixel_on_i,
  input  logic [9:0]        read_index_i,
  output logic              status_o,
  output logic [7:0]        read_byte_o
);
  import pfde_pkg::*;

  localparam int FB_PAGES = (DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int FB_DEPTH = DISP_WIDTH * FB_PAGES;
  localparam int AW       = $clog2(FB_DEPTH);
  localparam logic [8:0] W9 = 9'(DISP_WIDTH);
  localparam logic [8:0] H9 = 9'(DISP_HEIGHT);

  logic [7:0]    frame_store_q [FB_DEPTH];
  logic [7:0]    rdata_q;

  cmd_e          cmd_q;
  logic [7:0]    px_q, py_q, last_x_q, col_q;
  logic [4:0]    last_page_q, page_q;
  logic [2:0]    last_row_q;
  logic          on_q, bad_q, empty_q, ridx_ok_q;
  logic [9:0]    ridx_q;
  logic [AW-1:0] base_q, clr_q;
  logic          status_q;
  logic [7:0]    rbyte_q;

  logic          is_draw, on_disp;
  logic [7:0]    size_w, size_h, last_x, last_y;
  logic [8:0]    ex9, ey9, ex_c, ey_c;
  logic [AW-1:0] pix_addr, rd_addr, wr_addr;
  logic [15:0]   ridx_ext;
  logic [2:0]    row_lo, row_hi;
  logic [7:0]    mask, wdata;

  assign is_draw = (cmd_e'(command_i) == CMD_DRAW);
  assign on_disp = ({1'b0, pos_x_i} < W9) && ({1'b0, pos_y_i} < H9);
  assign size_w  = is_draw ? 8'd1 : rect_width_i;
  assign size_h  = is_draw ? 8'd1 : rect_height_i;
  assign ex9     = {1'b0, pos_x_i} + {1'b0, size_w};
  assign ey9     = {1'b0, pos_y_i} + {1'b0, size_h};
  assign ex_c    = (ex9 > W9) ? W9 : ex9;
  assign ey_c    = (ey9 > H9) ? H9 : ey9;
  assign last_x  = 8'(ex_c - 9'd1);
  assign last_y  = 8'(ey_c - 9'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= cmd_e'(command_i);
      px_q        <= pos_x_i;
      py_q        <= pos_y_i;
      on_q        <= pixel_on_i;
      ridx_q      <= read_index_i;
      ridx_ok_q   <= {6'd0, read_index_i} < 16'(FB_DEPTH);
      bad_q       <= (cmd_e'(command_i) == CMD_DRAW || cmd_e'(command_i) == CMD_FILL)
                     && !on_disp;
      empty_q     <= (size_w == 8'd0) || (size_h == 8'd0);
      last_x_q    <= last_x;
      last_page_q <= last_y[7:3];
      last_row_q  <= last_y[2:0];
      col_q       <= pos_x_i;
      page_q      <= pos_y_i[7:3];
      base_q      <= AW'(int'(pos_y_i[7:3]) * DISP_WIDTH);
    end else if (cmd_i.wr) begin
      if (col_q == last_x_q) begin
        col_q  <= px_q;
        page_q <= page_q + 5'd1;
        base_q <= base_q + AW'(DISP_WIDTH);
      end else begin
        col_q <= col_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.load) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign pix_addr = base_q + AW'(col_q);
  assign ridx_ext = 16'(ridx_q);
  assign rd_addr  = (cmd_q == CMD_READ) ? ridx_ext[AW-1:0] : pix_addr;
  assign wr_addr  = cmd_i.clr_step ? clr_q : pix_addr;

  assign row_lo = (page_q == py_q[7:3]) ? py_q[2:0] : 3'd0;
  assign row_hi = (page_q == last_page_q) ? last_row_q : 3'd7;
  assign mask   = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
  assign wdata  = cmd_i.clr_step ? 8'd0 : (on_q ? (rdata_q | mask) : (rdata_q & ~mask));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr || cmd_i.clr_step) begin
      frame_store_q[wr_addr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= frame_store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= bad_q ? ST_BAD_START : ST_OK;
      rbyte_q  <= (cmd_q == CMD_READ && ridx_ok_q) ? rdata_q : 8'd0;
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.bad       = bad_q;
  assign sts_o.empty     = empty_q;
  assign sts_o.last_byte = (col_q == last_x_q) && (page_q == last_page_q);
  assign sts_o.clr_last  = (clr_q == AW'(FB_DEPTH - 1));

  assign status_o    = status_q;
  assign read_byte_o = rbyte_q;

endmodule

>>> hdl/page_framebuffer_draw_engine_unit.sv
// Channel  Direction  Handshake          Item
// in_i     sink       valid/ready        command, pos_x, pos_y, rect_width, rect_height,
//                                        pixel_on, read_index
// out_o    source     valid/ready        status, read_byte
//
// One item is worked at a time; the frame memory has one write and one read port.
// Draw pixel and fill do one read and one write of the frame memory for each byte touched;
// a rejected or empty draw or fill touches no byte; read byte does one read; clear all
// writes zero to every byte.
// After reset a clearing pass writes zero to every byte (1024 bytes at the default
// size), with in_i.ready low. A finished result waits in the output register;
// the next item is taken meanwhile and holds at its end until out_o takes the old one.
module page_framebuffer_draw_engine_unit #(
  parameter int DISP_WIDTH  = pfde_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = pfde_pkg::DISP_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfde_in_if.sink           in_i,
  pfde_out_if.source        out_o
);
  import pfde_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  pfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  pfde_dp #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .command_i     (in_i.command),
    .pos_x_i       (in_i.pos_x),
    .pos_y_i       (in_i.pos_y),
    .rect_width_i  (in_i.rect_width),
    .rect_height_i (in_i.rect_height),
    .pixel_on_i    (in_i.pixel_on),
    .read_index_i  (in_i.read_index),
    .status_o      (out_o.status),
    .read_byte_o   (out_o.read_byte)
  );

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.res_load |-> (!out_o.valid || out_o.ready))
    else $error("result loaded over a pending result");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.wr |-> $past(dp_cmd.rd))
    else $error("memory write without preceding read");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.wr && dp_cmd.clr_step))
    else $error("pixel write and clear write in the same cycle");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken while one is in work");

endmodule
